// File: sv/tlcv_pkg.sv
package tlcv_pkg;

   // sizing of the class window and the tally bank
   localparam int HISTORY_DEPTH = 20;
   localparam int CLASS_COUNT   = 8;

   // fixed field widths
   localparam int CLASS_W = 3;
   localparam int TIME_W  = 32;
   localparam int RUN_W   = 16;
   localparam int VOTE_W  = 5;

   // widths that follow the window and tally sizes
   localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
   localparam int HEAD_W    = $clog2(HISTORY_DEPTH);
   localparam int TALLY_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int CLS_IDX_W = $clog2(CLASS_COUNT);
   localparam int CMP_W     = (FILL_W > VOTE_W) ? FILL_W : VOTE_W;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LOST = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOTE_MIN = 1'd1;

   localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_HIT   = 2'd1,
      OP_MISS  = 2'd2
   } op_type;

   // one request as held in the input register
   typedef struct packed {
      logic [1:0]         opcode;
      logic [TIME_W-1:0]  time_us;
      logic [CLASS_W-1:0] object_class;
   } req_type;

   // one response as held in the output register
   typedef struct packed {
      logic [CLASS_W-1:0] result_class;
      logic [RUN_W-1:0]   track_age;
      logic [RUN_W-1:0]   visible_run;
      logic [RUN_W-1:0]   invisible_run;
      logic               deleted;
      logic [FILL_W-1:0]  history_fill;
   } rsp_type;

   // window update command
   typedef struct packed {
      logic               push;
      logic               clear;
      logic [CLASS_W-1:0] cls;
   } win_ctl_type;

   // window status toward the track logic
   typedef struct packed {
      logic [CLASS_W-1:0] vote_class;
      logic [FILL_W-1:0]  fill;
      logic [FILL_W-1:0]  fill_next;
   } win_stat_type;

   // configuration register values
   typedef struct packed {
      logic [TIME_W-1:0] max_lost_time_us;
      logic [VOTE_W-1:0] vote_min_history;
   } cfg_type;

   // saturate an out-of-range class to the top class
   function automatic logic [CLASS_W-1:0] clamp_class(input logic [CLASS_W-1:0] c);
      logic [CLASS_W-1:0] r;
      r = c;
      if (int'(c) >= CLASS_COUNT) begin
         r = CLASS_W'(CLASS_COUNT - 1);
      end
      return r;
   endfunction

   function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
      logic [RUN_W-1:0] r;
      r = (v == RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
      return r;
   endfunction

endpackage

// File: sv/tlcv_if.sv
interface tlcv_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic [tlcv_pkg::TIME_W-1:0]  time_us;
   logic [tlcv_pkg::CLASS_W-1:0] object_class;

   modport source (output valid, output opcode, output time_us, output object_class,
                   input ready);
   modport sink (input valid, input opcode, input time_us, input object_class,
                 output ready);
endinterface

interface tlcv_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tlcv_pkg::CLASS_W-1:0] result_class;
   logic [tlcv_pkg::RUN_W-1:0]   track_age;
   logic [tlcv_pkg::RUN_W-1:0]   visible_run;
   logic [tlcv_pkg::RUN_W-1:0]   invisible_run;
   logic                         deleted;
   logic [tlcv_pkg::FILL_W-1:0]  history_fill;

   modport source (output valid, output result_class, output track_age,
                   output visible_run, output invisible_run, output deleted,
                   output history_fill, input ready);
   modport sink (input valid, input result_class, input track_age,
                 input visible_run, input invisible_run, input deleted,
                 input history_fill, output ready);
endinterface

// File: sv/tlcv_window.sv
module tlcv_window (
   input  logic                   clock,
   input  logic                   reset,
   input  tlcv_pkg::win_ctl_type  ctl,
   output tlcv_pkg::win_stat_type stat
);

   logic [tlcv_pkg::CLASS_W-1:0] window_ff [tlcv_pkg::HISTORY_DEPTH];
   logic [tlcv_pkg::TALLY_W-1:0] tally_ff  [tlcv_pkg::CLASS_COUNT];
   logic [tlcv_pkg::TALLY_W-1:0] tally_in  [tlcv_pkg::CLASS_COUNT];
   logic [tlcv_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [tlcv_pkg::HEAD_W-1:0]  head_ff, head_in;

   logic                           full;
   logic [tlcv_pkg::CLASS_W-1:0]   oldest;
   logic [tlcv_pkg::HEAD_W:0]      wr_sum;
   logic [tlcv_pkg::HEAD_W-1:0]    wr_idx;
   logic [tlcv_pkg::CLS_IDX_W-1:0] best_idx;
   logic [tlcv_pkg::TALLY_W-1:0]   best_cnt;

   assign full   = (fill_ff == tlcv_pkg::FILL_W'(tlcv_pkg::HISTORY_DEPTH));
   assign oldest = window_ff[head_ff];

   // write slot: oldest entry when full, else first free slot after head
   always_comb begin
      wr_sum = (tlcv_pkg::HEAD_W+1)'(head_ff) + (tlcv_pkg::HEAD_W+1)'(fill_ff);
      if (wr_sum >= (tlcv_pkg::HEAD_W+1)'(tlcv_pkg::HISTORY_DEPTH)) begin
         wr_sum = wr_sum - (tlcv_pkg::HEAD_W+1)'(tlcv_pkg::HISTORY_DEPTH);
      end
      wr_idx = full ? head_ff : wr_sum[tlcv_pkg::HEAD_W-1:0];
   end

   // fill and head next values
   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      if (ctl.clear) begin
         fill_in = tlcv_pkg::FILL_W'(1);
         head_in = '0;
      end else if (ctl.push) begin
         if (full) begin
            head_in = (head_ff == tlcv_pkg::HEAD_W'(tlcv_pkg::HISTORY_DEPTH - 1)) ?
                      '0 : head_ff + tlcv_pkg::HEAD_W'(1);
         end else begin
            fill_in = fill_ff + tlcv_pkg::FILL_W'(1);
         end
      end
   end

   // tally update: drop the evicted class, count the pushed one
   always_comb begin
      for (int k = 0; k < tlcv_pkg::CLASS_COUNT; k++) begin
         tally_in[k] = tally_ff[k];
         if (ctl.clear) begin
            tally_in[k] = (tlcv_pkg::CLS_IDX_W'(ctl.cls) == tlcv_pkg::CLS_IDX_W'(k)) ?
                          tlcv_pkg::TALLY_W'(1) : '0;
         end else if (ctl.push) begin
            if (full && tlcv_pkg::CLS_IDX_W'(oldest) == tlcv_pkg::CLS_IDX_W'(k) &&
                tally_ff[k] != '0) begin
               tally_in[k] = tally_in[k] - tlcv_pkg::TALLY_W'(1);
            end
            if (tlcv_pkg::CLS_IDX_W'(ctl.cls) == tlcv_pkg::CLS_IDX_W'(k)) begin
               tally_in[k] = tally_in[k] + tlcv_pkg::TALLY_W'(1);
            end
         end
      end
   end

   // majority over the current tally, ties to the lowest class
   always_comb begin
      best_idx = '0;
      best_cnt = tally_ff[0];
      for (int k = 1; k < tlcv_pkg::CLASS_COUNT; k++) begin
         if (tally_ff[k] > best_cnt) begin
            best_idx = tlcv_pkg::CLS_IDX_W'(k);
            best_cnt = tally_ff[k];
         end
      end
   end

   assign stat.vote_class = tlcv_pkg::CLASS_W'(best_idx);
   assign stat.fill       = fill_ff;
   assign stat.fill_next  = fill_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         head_ff <= '0;
         for (int k = 0; k < tlcv_pkg::CLASS_COUNT; k++) begin
            tally_ff[k] <= '0;
         end
      end else begin
         fill_ff <= fill_in;
         head_ff <= head_in;
         for (int k = 0; k < tlcv_pkg::CLASS_COUNT; k++) begin
            tally_ff[k] <= tally_in[k];
         end
      end
   end

   // window entries, valid only below the fill
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         window_ff[0] <= ctl.cls;
      end else if (ctl.push) begin
         window_ff[wr_idx] <= ctl.cls;
      end
   end

endmodule

// File: sv/tlcv_track.sv
module tlcv_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  tlcv_pkg::req_type      item,
   input  tlcv_pkg::cfg_type      cfg,
   input  tlcv_pkg::win_stat_type win,
   output tlcv_pkg::rsp_type      rsp_next
);

   logic [tlcv_pkg::RUN_W-1:0]   age_ff, age_in;
   logic [tlcv_pkg::RUN_W-1:0]   hit_run_ff, hit_run_in;
   logic [tlcv_pkg::RUN_W-1:0]   miss_run_ff, miss_run_in;
   logic [tlcv_pkg::TIME_W-1:0]  last_hit_ff, last_hit_in;
   logic                         deleted_ff, deleted_in;
   logic [tlcv_pkg::CLASS_W-1:0] last_class_ff, last_class_in;

   logic [tlcv_pkg::TIME_W-1:0]  lost_time;
   logic                         vote_ok;
   logic [tlcv_pkg::CLASS_W-1:0] hit_class;

   assign lost_time = item.time_us - last_hit_ff;
   assign vote_ok   = tlcv_pkg::CMP_W'(win.fill) > tlcv_pkg::CMP_W'(cfg.vote_min_history);
   assign hit_class = vote_ok ? win.vote_class : item.object_class;

   // lifecycle next state per opcode
   always_comb begin
      age_in        = age_ff;
      hit_run_in    = hit_run_ff;
      miss_run_in   = miss_run_ff;
      last_hit_in   = last_hit_ff;
      deleted_in    = deleted_ff;
      last_class_in = last_class_ff;
      if (go) begin
         case (item.opcode)
            tlcv_pkg::OP_START: begin
               age_in        = tlcv_pkg::RUN_W'(1);
               hit_run_in    = '0;
               miss_run_in   = '0;
               last_hit_in   = item.time_us;
               deleted_in    = 1'b0;
               last_class_in = item.object_class;
            end
            tlcv_pkg::OP_HIT: begin
               age_in        = tlcv_pkg::sat_inc(age_ff);
               hit_run_in    = tlcv_pkg::sat_inc(hit_run_ff);
               miss_run_in   = '0;
               last_hit_in   = item.time_us;
               last_class_in = hit_class;
            end
            tlcv_pkg::OP_MISS: begin
               age_in      = tlcv_pkg::sat_inc(age_ff);
               miss_run_in = tlcv_pkg::sat_inc(miss_run_ff);
               hit_run_in  = '0;
               if (lost_time > cfg.max_lost_time_us) begin
                  deleted_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response fields show the state after this request
   assign rsp_next.result_class  = last_class_in;
   assign rsp_next.track_age     = age_in;
   assign rsp_next.visible_run   = hit_run_in;
   assign rsp_next.invisible_run = miss_run_in;
   assign rsp_next.deleted       = deleted_in;
   assign rsp_next.history_fill  = win.fill_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff        <= '0;
         hit_run_ff    <= '0;
         miss_run_ff   <= '0;
         last_hit_ff   <= '0;
         deleted_ff    <= 1'b0;
         last_class_ff <= '0;
      end else begin
         age_ff        <= age_in;
         hit_run_ff    <= hit_run_in;
         miss_run_ff   <= miss_run_in;
         last_hit_ff   <= last_hit_in;
         deleted_ff    <= deleted_in;
         last_class_ff <= last_class_in;
      end
   end

endmodule

// File: sv/track_lifecycle_class_vote.sv
// an accepted request is held in the input register, its response then in the
// output register; one request per cycle while the response side is ready; the
// tally update and class vote are combinational between the input register and
// the output register
// reset (synchronous): window empty, tallies and counters zero, deleted clear,
// max_lost_time_us = 400000, vote_min_history = 5
module track_lifecycle_class_vote (
   input  logic                               clock,
   input  logic                               reset,
   tlcv_req_if.sink                           req_bus,
   tlcv_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [tlcv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tlcv_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   tlcv_pkg::req_type in_ff;
   logic              out_valid_ff, out_valid_in;
   tlcv_pkg::rsp_type out_ff;
   tlcv_pkg::cfg_type cfg_ff, cfg_in;

   logic                   take;
   logic                   advance;
   tlcv_pkg::req_type      item;
   tlcv_pkg::win_ctl_type  win_ctl;
   tlcv_pkg::win_stat_type win_stat;
   tlcv_pkg::rsp_type      rsp_next;

   // handshake: input stage drains into the output register
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // clamped request out of the input register
   always_comb begin
      item              = in_ff;
      item.object_class = tlcv_pkg::clamp_class(in_ff.object_class);
   end

   // window command
   always_comb begin
      win_ctl.cls   = item.object_class;
      win_ctl.clear = advance && (item.opcode == tlcv_pkg::OP_START);
      win_ctl.push  = advance && (item.opcode == tlcv_pkg::OP_START ||
                                  item.opcode == tlcv_pkg::OP_HIT);
   end

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tlcv_pkg::CSR_MAX_LOST: cfg_in.max_lost_time_us = csr_wdata;
            tlcv_pkg::CSR_VOTE_MIN: cfg_in.vote_min_history =
                                       csr_wdata[tlcv_pkg::VOTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tlcv_window u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .stat  (win_stat)
   );

   tlcv_track u_track (
      .clock    (clock),
      .reset    (reset),
      .go       (advance),
      .item     (item),
      .cfg      (cfg_ff),
      .win      (win_stat),
      .rsp_next (rsp_next)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
         cfg_ff.max_lost_time_us     <= tlcv_pkg::TIME_W'(400000);
         cfg_ff.vote_min_history     <= tlcv_pkg::VOTE_W'(5);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.opcode       <= req_bus.opcode;
         in_ff.time_us      <= req_bus.time_us;
         in_ff.object_class <= req_bus.object_class;
      end
      if (advance) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.result_class  = out_ff.result_class;
   assign rsp_bus.track_age     = out_ff.track_age;
   assign rsp_bus.visible_run   = out_ff.visible_run;
   assign rsp_bus.invisible_run = out_ff.invisible_run;
   assign rsp_bus.deleted       = out_ff.deleted;
   assign rsp_bus.history_fill  = out_ff.history_fill;

endmodule

// File: tb/tlcv_track_checker.sv
`timescale 1ns / 100ps

module tlcv_track_checker (
   input  logic                            clock,
   input  logic                            reset,
   tlcv_req_if                             req_mon,
   tlcv_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [tlcv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlcv_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              reports_pending
);
   import tlcv_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int DUE_DEPTH    = 16;

   // register copies as seen on the configuration port
   logic [TIME_W-1:0]  lost_limit;
   logic [VOTE_W-1:0]  vote_floor;

   // predicted track state
   logic [CLASS_W-1:0] class_ring [HISTORY_DEPTH];
   int                 ring_fill;
   int                 ring_head;
   int                 class_votes [CLASS_COUNT];
   logic [RUN_W-1:0]   age_q;
   logic [RUN_W-1:0]   hits_q;
   logic [RUN_W-1:0]   misses_q;
   logic [TIME_W-1:0]  last_seen_us;
   logic               gone_q;
   logic [CLASS_W-1:0] reported_class;

   // expected responses in request order, ring with running indexes
   rsp_type            reports_due [DUE_DEPTH];
   int                 due_wr = 0;
   int                 due_rd = 0;
   int                 mismatches = 0;

   function automatic logic [RUN_W-1:0] bump_sat(input logic [RUN_W-1:0] v);
      return (v == RUN_MAX) ? v : v + RUN_W'(1);
   endfunction

   task automatic clear_ring();
      for (int k = 0; k < HISTORY_DEPTH; k++) class_ring[k] = '0;
      for (int k = 0; k < CLASS_COUNT; k++) class_votes[k] = 0;
      ring_fill = 0;
      ring_head = 0;
   endtask

   // append a class, dropping the oldest one once the window is full
   task automatic push_ring(input logic [CLASS_W-1:0] cls);
      logic [CLASS_W-1:0] oldest;
      if (ring_fill >= HISTORY_DEPTH) begin
         oldest = class_ring[ring_head];
         if (class_votes[oldest] > 0) class_votes[oldest]--;
         class_ring[ring_head] = cls;
         ring_head = (ring_head + 1) % HISTORY_DEPTH;
      end else begin
         class_ring[(ring_head + ring_fill) % HISTORY_DEPTH] = cls;
         ring_fill++;
      end
      class_votes[cls]++;
   endtask

   // most frequent class, lowest class wins a tie
   function automatic logic [CLASS_W-1:0] majority_class();
      int best;
      best = 0;
      for (int k = 1; k < CLASS_COUNT; k++) begin
         if (class_votes[k] > class_votes[best]) best = k;
      end
      return CLASS_W'(best);
   endfunction

   task automatic advance_track(input req_type frame, output rsp_type report);
      logic [CLASS_W-1:0] cls;
      logic [CLASS_W-1:0] picked;
      logic [TIME_W-1:0]  gap_us;
      cls = (int'(frame.object_class) >= CLASS_COUNT) ? CLASS_W'(CLASS_COUNT - 1)
                                                      : frame.object_class;
      case (frame.opcode)
         OP_START: begin
            clear_ring();
            push_ring(cls);
            reported_class = cls;
            age_q          = RUN_W'(1);
            hits_q         = '0;
            misses_q       = '0;
            last_seen_us   = frame.time_us;
            gone_q         = 1'b0;
         end
         OP_HIT: begin
            // vote on the window before this detection enters it
            picked = cls;
            if (ring_fill > int'(vote_floor)) picked = majority_class();
            push_ring(cls);
            reported_class = picked;
            age_q          = bump_sat(age_q);
            hits_q         = bump_sat(hits_q);
            misses_q       = '0;
            last_seen_us   = frame.time_us;
         end
         OP_MISS: begin
            age_q    = bump_sat(age_q);
            misses_q = bump_sat(misses_q);
            hits_q   = '0;
            gap_us   = frame.time_us - last_seen_us;
            if (gap_us > lost_limit) gone_q = 1'b1;
         end
         default: begin
         end
      endcase
      report.result_class  = reported_class;
      report.track_age     = age_q;
      report.visible_run   = hits_q;
      report.invisible_run = misses_q;
      report.deleted       = gone_q;
      report.history_fill  = FILL_W'(ring_fill);
   endtask

   task automatic flag_report(input bit had_want, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         if (!had_want)
            $display("%0t: response with no request pending: ", $time,
                     "cls %0d age %0d vis %0d inv %0d del %0d fill %0d",
                     got.result_class, got.track_age, got.visible_run,
                     got.invisible_run, got.deleted, got.history_fill);
         else
            $display("%0t: response mismatch: ", $time,
                     "expected cls %0d age %0d vis %0d inv %0d del %0d fill %0d, ",
                     want.result_class, want.track_age, want.visible_run,
                     want.invisible_run, want.deleted, want.history_fill,
                     "got cls %0d age %0d vis %0d inv %0d del %0d fill %0d",
                     got.result_class, got.track_age, got.visible_run,
                     got.invisible_run, got.deleted, got.history_fill);
      end
   endtask

   always @(posedge clock) begin
      req_type frame;
      rsp_type got;
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         lost_limit = TIME_W'(400000);
         vote_floor = VOTE_W'(5);
         clear_ring();
         age_q          = '0;
         hits_q         = '0;
         misses_q       = '0;
         last_seen_us   = '0;
         gone_q         = 1'b0;
         reported_class = '0;
         due_wr         = 0;
         due_rd         = 0;
      end else begin
         // check the response before queuing a new request on the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.result_class  = rsp_mon.result_class;
            got.track_age     = rsp_mon.track_age;
            got.visible_run   = rsp_mon.visible_run;
            got.invisible_run = rsp_mon.invisible_run;
            got.deleted       = rsp_mon.deleted;
            got.history_fill  = rsp_mon.history_fill;
            if (due_wr == due_rd) begin
               flag_report(1'b0, got, got);
            end else begin
               want = reports_due[due_rd % DUE_DEPTH];
               due_rd++;
               if (got.result_class !== want.result_class ||
                   got.track_age !== want.track_age ||
                   got.visible_run !== want.visible_run ||
                   got.invisible_run !== want.invisible_run ||
                   got.deleted !== want.deleted ||
                   got.history_fill !== want.history_fill)
                  flag_report(1'b1, want, got);
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_LOST: lost_limit = csr_wdata[TIME_W-1:0];
               CSR_VOTE_MIN: vote_floor = csr_wdata[VOTE_W-1:0];
               default: begin
               end
            endcase
         end
         // accepted request
         if (req_mon.valid && req_mon.ready) begin
            frame.opcode       = req_mon.opcode;
            frame.time_us      = req_mon.time_us;
            frame.object_class = req_mon.object_class;
            advance_track(frame, fresh);
            reports_due[due_wr % DUE_DEPTH] = fresh;
            due_wr++;
         end
      end
      fail_count      <= mismatches;
      reports_pending <= due_wr - due_rd;
   end

endmodule

// File: tb/track_lifecycle_class_vote_tb.sv
`timescale 1ns / 100ps

module track_lifecycle_class_vote_tb;
   import tlcv_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         GAP_MAX      = 13;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         PHASE_ITEMS  = 250;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  rsp_ready_q = 1'b0;
   bit                    send_idle = 1'b0;
   bit                    recv_idle = 1'b0;
   int                    rsp_hold = 0;
   int                    stall_cycles = 0;
   int                    fail_count;
   int                    reports_pending;
   logic [TIME_W-1:0]     lost_limit_now = TIME_W'(400000);

   tlcv_req_if req_if ();
   tlcv_rsp_if rsp_if ();

   assign rsp_if.ready = rsp_ready_q;

   track_lifecycle_class_vote u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tlcv_track_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .reports_pending (reports_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side: random hold-off after each accepted response when idling is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            rsp_hold = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
         else if (rsp_hold > 0)
            rsp_hold--;
         rsp_ready_q <= (rsp_hold == 0);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("track_lifecycle_class_vote_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one request, after a random gap when idling is on
   task automatic send_req(input logic [1:0] op, input logic [TIME_W-1:0] t,
                           input logic [CLASS_W-1:0] cls);
      int gap;
      gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.opcode       <= op;
      req_if.time_us      <= t;
      req_if.object_class <= cls;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_reports();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (reports_pending != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_limits(input logic [TIME_W-1:0] lost, input logic [VOTE_W-1:0] vote);
      drain_reports();
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_LOST;
      csr_wdata <= CSR_DATA_W'(lost);
      @(posedge clock);
      csr_index <= CSR_VOTE_MIN;
      csr_wdata <= CSR_DATA_W'(vote);
      @(posedge clock);
      csr_we <= 1'b0;
      lost_limit_now = lost;
   endtask

   // mostly whole tracks with a dominant class, some raw noise
   task automatic run_tracks(input int n_items);
      int                 sent;
      int                 frames;
      logic [TIME_W-1:0]  t_now;
      logic [CLASS_W-1:0] usual_cls;
      logic [CLASS_W-1:0] cls;
      logic [1:0]         op;
      sent = 0;
      while (sent < n_items) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            frames = $urandom_range(1, 4);
            for (int k = 0; k < frames; k++)
               send_req(2'($urandom_range(0, 3)), $urandom, 3'($urandom_range(0, 7)));
            sent += frames;
         end else begin
            t_now     = $urandom;
            usual_cls = 3'($urandom_range(0, 7));
            frames    = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 15);
            send_req(OP_START, t_now, usual_cls);
            for (int k = 0; k < frames; k++) begin
               // time steps around the lost limit, plus wild jumps
               case ($urandom_range(0, 9))
                  0: t_now = t_now + lost_limit_now;
                  1: t_now = t_now + lost_limit_now + TIME_W'(1);
                  2: t_now = t_now + $urandom;
                  3: begin
                  end
                  default: t_now = t_now + $urandom_range(1, 50000);
               endcase
               op  = ($urandom_range(0, 9) < 7) ? OP_HIT : OP_MISS;
               cls = ($urandom_range(0, 9) < 6) ? usual_cls : 3'($urandom_range(0, 7));
               send_req(op, t_now, cls);
            end
            sent += frames + 1;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.opcode       <= '0;
      req_if.time_us      <= '0;
      req_if.object_class <= '0;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset settings
      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_req(OP_HIT, 32'd100, 3'd7);           // hit with no track open
      send_req(OP_MISS, 32'd0, 3'd0);            // wrapped gap deletes
      send_req(OP_UNUSED, 32'hFFFF_FFFF, 3'd5);
      send_req(OP_START, 32'hFFFF_FFF0, 3'd3);
      send_req(OP_HIT, 32'hFFFF_FFF8, 3'd3);
      send_req(OP_HIT, 32'd5, 3'd1);             // time wraps
      send_req(OP_HIT, 32'd10, 3'd1);
      send_req(OP_HIT, 32'd20, 3'd0);
      send_req(OP_HIT, 32'd30, 3'd0);            // window at threshold, no vote
      send_req(OP_HIT, 32'd40, 3'd7);            // three-way tie votes lowest
      send_req(OP_MISS, 32'd50, 3'd2);
      send_req(OP_MISS, 32'd400040, 3'd2);       // gap equal to limit
      send_req(OP_MISS, 32'd400041, 3'd6);       // gap over limit
      send_req(OP_HIT, 32'd400100, 3'd2);        // hit on a deleted track
      send_req(OP_UNUSED, 32'd0, 3'd0);
      send_req(OP_START, 32'd0, 3'd7);           // restart clears deleted
      for (int k = 0; k < 8; k++) send_req(OP_HIT, 32'(100 * k + 100), 3'(k));

      // random tracks under several register settings
      program_limits(32'd0, 5'd0);
      run_tracks(PHASE_ITEMS);
      program_limits(32'hFFFF_FFFF, 5'd20);
      run_tracks(PHASE_ITEMS);
      program_limits(32'd1000, 5'd31);
      run_tracks(PHASE_ITEMS);
      program_limits($urandom, 5'($urandom_range(0, 20)));
      run_tracks(PHASE_ITEMS);
      program_limits(32'd400000, 5'd5);
      run_tracks(PHASE_ITEMS);
      program_limits(32'($urandom_range(0, 2000000)), 5'd1);
      run_tracks(PHASE_ITEMS);

      drain_reports();
      if (fail_count == 0)
         $display("track_lifecycle_class_vote_tb OK");
      else
         $display("track_lifecycle_class_vote_tb NOT OK");
      $finish;
   end

endmodule
